// File: hw/rtl/recc_pkg.sv
// Shared widths, constants and types of the rotated ellipse conic coefficient unit.
package recc_pkg;

    localparam int IN_W    = 16;
    localparam int X_W     = 31;
    localparam int X2_W    = 32;
    localparam int T_W     = 31;
    localparam int TRIG_W  = 16;
    localparam int COEF_W  = 64;
    localparam int ACC_W   = 128;

    localparam int SIN_STEPS  = 7;
    localparam int COS_STEPS  = 8;
    localparam int STEP_LAT   = 3;
    localparam int SINCOS_LAT = 2 + COS_STEPS * STEP_LAT + 1;
    localparam int COEF_LAT   = 8;

    localparam logic [T_W-1:0] Q30_ONE = 31'h4000_0000;
    localparam logic [49:0]    PI_Q48  = 50'h3243F6A8885A3;

    typedef struct packed {
        logic        [IN_W-1:0] semi_axis_a;
        logic        [IN_W-1:0] semi_axis_b;
        logic signed [IN_W-1:0] center_x;
        logic signed [IN_W-1:0] center_y;
    } recc_geom_t;

endpackage

// File: hw/rtl/recc_step.sv
// One term of the sine or cosine series: multiply, divide by a constant, subtract from one.
module recc_step #(
    parameter int DIV = 6,
    parameter int SW  = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [recc_pkg::X2_W-1:0]     x2_in,
    input  logic [recc_pkg::T_W-1:0]      t_in,
    input  logic [SW-1:0]                 side_in,
    output logic                          out_valid,
    output logic [recc_pkg::X2_W-1:0]     x2_out,
    output logic [recc_pkg::T_W-1:0]      t_out,
    output logic [SW-1:0]                 side_out
);

    localparam longint unsigned RECIP = (64'd1 << 32) / DIV;
    localparam logic [31:0] MUL  = 32'(RECIP);
    localparam logic [8:0]  DIVL = 9'(DIV);

    logic        va_reg, vb_reg, vc_reg;
    logic [31:0] p_a_reg, x2_a_reg;
    logic [SW-1:0] side_a_reg, side_b_reg, side_c_reg;
    logic [31:0] q0_b_reg, p_b_reg, x2_b_reg, x2_c_reg;
    logic [recc_pkg::T_W-1:0] t_c_reg;

    logic [62:0] prod_a;
    logic [63:0] prod_b;
    logic [40:0] prod_c;
    logic [40:0] rem_c;
    logic [31:0] q_c;
    logic [recc_pkg::T_W-1:0] t_next;

    always_comb begin
        prod_a = {31'b0, x2_in} * {32'b0, t_in};
        prod_b = {32'b0, p_a_reg} * {32'b0, MUL};
        prod_c = {9'b0, q0_b_reg} * {32'b0, DIVL};
        rem_c  = {9'b0, p_b_reg} - prod_c;
        q_c    = q0_b_reg + ((rem_c >= {32'b0, DIVL}) ? 32'd1 : 32'd0);
        if (q_c >= {1'b0, recc_pkg::Q30_ONE}) begin
            t_next = '0;
        end else begin
            t_next = recc_pkg::Q30_ONE - q_c[recc_pkg::T_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_a_reg    <= prod_a[61:30];
            x2_a_reg   <= x2_in;
            side_a_reg <= side_in;
            q0_b_reg   <= prod_b[63:32];
            p_b_reg    <= p_a_reg;
            x2_b_reg   <= x2_a_reg;
            side_b_reg <= side_a_reg;
            t_c_reg    <= t_next;
            x2_c_reg   <= x2_b_reg;
            side_c_reg <= side_b_reg;
        end
    end

    assign out_valid = vc_reg;
    assign x2_out    = x2_c_reg;
    assign t_out     = t_c_reg;
    assign side_out  = side_c_reg;

endmodule

// File: hw/rtl/recc_sincos.sv
// Pipelined sine and cosine of a binary angle, rounded to Q1.14.
module recc_sincos (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [recc_pkg::IN_W-1:0]         angle,
    output logic                              out_valid,
    output logic signed [recc_pkg::TRIG_W-1:0] sin_q14,
    output logic signed [recc_pkg::TRIG_W-1:0] cos_q14
);

    localparam int SN = recc_pkg::SIN_STEPS;
    localparam int CN = recc_pkg::COS_STEPS;

    logic                      v0_reg, v1_reg;
    logic [1:0]                quad0_reg, quad1_reg;
    logic [recc_pkg::X_W-1:0]  x0_reg, x1_reg;
    logic [recc_pkg::X2_W-1:0] x2_reg;
    logic [64:0]               prod_x;
    logic [61:0]               sq_x;

    logic                      sin_v   [0:SN];
    logic [recc_pkg::X2_W-1:0] sin_x2  [0:SN];
    logic [recc_pkg::T_W-1:0]  sin_t   [0:SN];
    logic [recc_pkg::X_W-1:0]  sin_x   [0:SN];
    logic                      cos_v   [0:CN];
    logic [recc_pkg::X2_W-1:0] cos_x2  [0:CN];
    logic [recc_pkg::T_W-1:0]  cos_t   [0:CN];
    logic [1:0]                cos_q   [0:CN];

    logic        sm_v_reg, sr_v_reg, sd_v_reg, out_v_reg;
    logic [31:0] sm_reg;
    logic [14:0] sr_reg, sd_reg;
    logic [61:0] prod_s;
    logic [32:0] s_sum;
    logic [31:0] c_sum;
    logic [14:0] c_mag;
    logic signed [recc_pkg::TRIG_W-1:0] sp, cp, sin_next, cos_next;
    logic signed [recc_pkg::TRIG_W-1:0] sin_reg, cos_reg;

    always_comb begin
        prod_x = 65'(angle[13:0]) * 65'(recc_pkg::PI_Q48) + (65'd1 << 32);
        sq_x   = {31'b0, x0_reg} * {31'b0, x0_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg    <= prod_x[63:33];
            quad0_reg <= angle[15:14];
            x1_reg    <= x0_reg;
            quad1_reg <= quad0_reg;
            x2_reg    <= sq_x[61:30];
        end
    end

    assign sin_v[0]  = v1_reg;
    assign sin_x2[0] = x2_reg;
    assign sin_t[0]  = recc_pkg::Q30_ONE;
    assign sin_x[0]  = x1_reg;
    assign cos_v[0]  = v1_reg;
    assign cos_x2[0] = x2_reg;
    assign cos_t[0]  = recc_pkg::Q30_ONE;
    assign cos_q[0]  = quad1_reg;

    for (genvar i = 0; i < SN; i++) begin : g_sin
        localparam int K = SN - i;
        recc_step #(.DIV((2 * K) * (2 * K + 1)), .SW(recc_pkg::X_W)) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (sin_v[i]),
            .x2_in    (sin_x2[i]),
            .t_in     (sin_t[i]),
            .side_in  (sin_x[i]),
            .out_valid(sin_v[i+1]),
            .x2_out   (sin_x2[i+1]),
            .t_out    (sin_t[i+1]),
            .side_out (sin_x[i+1])
        );
    end

    for (genvar i = 0; i < CN; i++) begin : g_cos
        localparam int K = CN - i;
        recc_step #(.DIV((2 * K - 1) * (2 * K)), .SW(2)) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (cos_v[i]),
            .x2_in    (cos_x2[i]),
            .t_in     (cos_t[i]),
            .side_in  (cos_q[i]),
            .out_valid(cos_v[i+1]),
            .x2_out   (cos_x2[i+1]),
            .t_out    (cos_t[i+1]),
            .side_out (cos_q[i+1])
        );
    end

    always_comb begin
        prod_s = {31'b0, sin_x[SN]} * {31'b0, sin_t[SN]};
        s_sum  = {1'b0, sm_reg} + 33'h8000;
        c_sum  = {1'b0, cos_t[CN]} + 32'h8000;
        c_mag  = c_sum[30:16];
        sp     = $signed({1'b0, sd_reg});
        cp     = $signed({1'b0, c_mag});
        case (cos_q[CN])
            2'd0: begin
                sin_next = sp;
                cos_next = cp;
            end
            2'd1: begin
                sin_next = cp;
                cos_next = -sp;
            end
            2'd2: begin
                sin_next = -sp;
                cos_next = -cp;
            end
            default: begin
                sin_next = -cp;
                cos_next = sp;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sm_v_reg  <= 1'b0;
            sr_v_reg  <= 1'b0;
            sd_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            sm_v_reg  <= sin_v[SN];
            sr_v_reg  <= sm_v_reg;
            sd_v_reg  <= sr_v_reg;
            out_v_reg <= sd_v_reg & cos_v[CN];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sm_reg  <= prod_s[61:30];
            sr_reg  <= s_sum[30:16];
            sd_reg  <= sr_reg;
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign out_valid = out_v_reg;
    assign sin_q14   = sin_reg;
    assign cos_q14   = cos_reg;

endmodule

// File: hw/rtl/recc_coef.sv
// Pipelined terms T1, T2, T3 and the six conic coefficients with exact wide products.
module recc_coef (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  recc_pkg::recc_geom_t                geom,
    input  logic signed [recc_pkg::TRIG_W-1:0]  sin_q14,
    input  logic signed [recc_pkg::TRIG_W-1:0]  cos_q14,
    output logic                                out_valid,
    output logic signed [recc_pkg::COEF_W-1:0]  coef_xx,
    output logic signed [recc_pkg::COEF_W-1:0]  coef_yy,
    output logic signed [recc_pkg::COEF_W-1:0]  coef_xy,
    output logic signed [recc_pkg::COEF_W-1:0]  coef_x,
    output logic signed [recc_pkg::COEF_W-1:0]  coef_y,
    output logic signed [recc_pkg::COEF_W-1:0]  coef_const
);

    localparam int NP = 7;
    localparam int AW = recc_pkg::ACC_W;
    localparam int CW = recc_pkg::COEF_W;

    logic [recc_pkg::COEF_LAT-1:0] v_reg;

    // Stage 1
    logic signed [31:0] ss_w, cc_w, sc_w;
    logic [28:0]        ss1_reg, cc1_reg;
    logic signed [29:0] sc1_reg;
    logic [31:0]        a21_reg, b21_reg;
    logic [30:0]        cxx1_reg, cyy1_reg;
    logic signed [31:0] cxy1_reg;
    logic signed [15:0] cx1_reg, cy1_reg;

    // Stage 2
    logic [60:0]        a2ss2_reg, b2cc2_reg, b2ss2_reg, a2cc2_reg;
    logic signed [32:0] dif_w;
    logic signed [62:0] dsc2_reg;
    logic [63:0]        ab2_reg;
    logic [30:0]        cxx2_reg, cyy2_reg;
    logic signed [31:0] cxy2_reg;
    logic signed [15:0] cx2_reg, cy2_reg;

    // Stage 3
    logic signed [63:0] t13_reg, t23_reg, t33_reg;
    logic [63:0]        ab3_reg;
    logic [30:0]        cxx3_reg, cyy3_reg;
    logic signed [31:0] cxy3_reg;
    logic signed [15:0] cx3_reg, cy3_reg;

    // Stage 4
    logic signed [63:0] xs [0:NP-1];
    logic signed [31:0] ys [0:NP-1];
    logic signed [63:0] ph_next [0:NP-1];
    logic signed [64:0] pl_next [0:NP-1];
    logic signed [63:0] ph4_reg [0:NP-1];
    logic signed [64:0] pl4_reg [0:NP-1];
    logic signed [CW-1:0] a4_reg, b4_reg, c4_reg;
    logic [63:0]        ab4_reg;

    // Stage 5
    logic signed [AW-1:0] p5_reg [0:NP-1];
    logic signed [CW-1:0] a5_reg, b5_reg, c5_reg;
    logic [63:0]          ab5_reg;

    // Stage 6
    logic signed [AW-1:0] dacc_w, eacc_w;
    logic signed [CW-1:0] d6_reg, e6_reg;
    logic signed [AW-1:0] fp6_reg, p66_reg, abs6_reg;
    logic signed [CW-1:0] a6_reg, b6_reg, c6_reg;

    // Stage 7
    logic signed [AW-1:0] f17_reg, abs7_reg;
    logic signed [CW-1:0] a7_reg, b7_reg, c7_reg, d7_reg, e7_reg;

    // Stage 8
    logic signed [AW-1:0] f_w;
    logic signed [CW-1:0] a8_reg, b8_reg, c8_reg, d8_reg, e8_reg, f8_reg;

    always_comb begin
        ss_w  = sin_q14 * sin_q14;
        cc_w  = cos_q14 * cos_q14;
        sc_w  = sin_q14 * cos_q14;
        dif_w = $signed({1'b0, b21_reg}) - $signed({1'b0, a21_reg});

        xs[0] = t13_reg;
        ys[0] = -($signed(32'(cx3_reg)) <<< 1);
        xs[1] = t23_reg;
        ys[1] = -$signed(32'(cy3_reg));
        xs[2] = t33_reg;
        ys[2] = -($signed(32'(cy3_reg)) <<< 1);
        xs[3] = t23_reg;
        ys[3] = -$signed(32'(cx3_reg));
        xs[4] = t13_reg;
        ys[4] = $signed({1'b0, cxx3_reg});
        xs[5] = t23_reg;
        ys[5] = cxy3_reg;
        xs[6] = t33_reg;
        ys[6] = $signed({1'b0, cyy3_reg});
        for (int i = 0; i < NP; i++) begin
            ph_next[i] = $signed(xs[i][63:32]) * ys[i];
            pl_next[i] = $signed({1'b0, xs[i][31:0]}) * $signed({{33{ys[i][31]}}, ys[i]});
        end

        dacc_w = p5_reg[0] + p5_reg[1];
        eacc_w = p5_reg[2] + p5_reg[3];
        f_w    = f17_reg - abs7_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[recc_pkg::COEF_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ss1_reg  <= ss_w[28:0];
            cc1_reg  <= cc_w[28:0];
            sc1_reg  <= sc_w[29:0];
            a21_reg  <= {16'b0, geom.semi_axis_a} * {16'b0, geom.semi_axis_a};
            b21_reg  <= {16'b0, geom.semi_axis_b} * {16'b0, geom.semi_axis_b};
            cxx1_reg <= 31'($signed(32'(geom.center_x)) * $signed(32'(geom.center_x)));
            cyy1_reg <= 31'($signed(32'(geom.center_y)) * $signed(32'(geom.center_y)));
            cxy1_reg <= $signed(32'(geom.center_x)) * $signed(32'(geom.center_y));
            cx1_reg  <= geom.center_x;
            cy1_reg  <= geom.center_y;

            a2ss2_reg <= {29'b0, a21_reg} * {32'b0, ss1_reg};
            b2cc2_reg <= {29'b0, b21_reg} * {32'b0, cc1_reg};
            b2ss2_reg <= {29'b0, b21_reg} * {32'b0, ss1_reg};
            a2cc2_reg <= {29'b0, a21_reg} * {32'b0, cc1_reg};
            dsc2_reg  <= $signed({{30{dif_w[32]}}, dif_w}) *
                         $signed({{33{sc1_reg[29]}}, sc1_reg});
            ab2_reg   <= {32'b0, a21_reg} * {32'b0, b21_reg};
            cxx2_reg  <= cxx1_reg;
            cyy2_reg  <= cyy1_reg;
            cxy2_reg  <= cxy1_reg;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;

            t13_reg  <= $signed({3'b0, a2ss2_reg} + {3'b0, b2cc2_reg});
            t33_reg  <= $signed({3'b0, b2ss2_reg} + {3'b0, a2cc2_reg});
            t23_reg  <= $signed({dsc2_reg, 1'b0});
            ab3_reg  <= ab2_reg;
            cxx3_reg <= cxx2_reg;
            cyy3_reg <= cyy2_reg;
            cxy3_reg <= cxy2_reg;
            cx3_reg  <= cx2_reg;
            cy3_reg  <= cy2_reg;

            for (int i = 0; i < NP; i++) begin
                ph4_reg[i] <= ph_next[i];
                pl4_reg[i] <= pl_next[i];
                p5_reg[i]  <= ($signed({{64{ph4_reg[i][63]}}, ph4_reg[i]}) <<< 32) +
                              $signed({{63{pl4_reg[i][64]}}, pl4_reg[i]});
            end
            a4_reg  <= t13_reg >>> 28;
            b4_reg  <= t33_reg >>> 28;
            c4_reg  <= t23_reg >>> 28;
            ab4_reg <= ab3_reg;

            a5_reg  <= a4_reg;
            b5_reg  <= b4_reg;
            c5_reg  <= c4_reg;
            ab5_reg <= ab4_reg;

            d6_reg   <= dacc_w[99:36];
            e6_reg   <= eacc_w[99:36];
            fp6_reg  <= p5_reg[4] + p5_reg[5];
            p66_reg  <= p5_reg[6];
            abs6_reg <= $signed({36'b0, ab5_reg, 28'b0});
            a6_reg   <= a5_reg;
            b6_reg   <= b5_reg;
            c6_reg   <= c5_reg;

            f17_reg  <= fp6_reg + p66_reg;
            abs7_reg <= abs6_reg;
            a7_reg   <= a6_reg;
            b7_reg   <= b6_reg;
            c7_reg   <= c6_reg;
            d7_reg   <= d6_reg;
            e7_reg   <= e6_reg;

            f8_reg <= f_w[107:44];
            a8_reg <= a7_reg;
            b8_reg <= b7_reg;
            c8_reg <= c7_reg;
            d8_reg <= d7_reg;
            e8_reg <= e7_reg;
        end
    end

    assign out_valid  = v_reg[recc_pkg::COEF_LAT-1];
    assign coef_xx    = a8_reg;
    assign coef_yy    = b8_reg;
    assign coef_xy    = c8_reg;
    assign coef_x     = d8_reg;
    assign coef_y     = e8_reg;
    assign coef_const = f8_reg;

endmodule

// File: hw/rtl/rotated_ellipse_conic_coeffs_unit.sv
// Top level of the rotated ellipse to general conic coefficient unit.
// An accepted item passes through the sine and cosine pipeline, whose depth is set by its eight
// cosine series steps, and then through the coefficient pipeline.
// Throughput is one item per cycle; while a result waits at the output, the whole pipeline holds.
// Reset (aresetn low at a clock edge) clears every valid bit; data registers are not reset.
module rotated_ellipse_conic_coeffs_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // semi_axis_a, semi_axis_b, rotation_angle, center_x, center_y
    input  logic [79:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // coef_xx, coef_yy, coef_xy, coef_x, coef_y, coef_const
    output logic [383:0] m_tdata
);

    localparam int DL = recc_pkg::SINCOS_LAT;

    logic en;
    logic sc_valid;
    logic signed [recc_pkg::TRIG_W-1:0] sin_q14, cos_q14;
    recc_pkg::recc_geom_t geom_in;
    recc_pkg::recc_geom_t geom_reg [0:DL-1];
    logic signed [recc_pkg::COEF_W-1:0] coef_xx, coef_yy, coef_xy, coef_x, coef_y, coef_const;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign geom_in.semi_axis_a = s_tdata[15:0];
    assign geom_in.semi_axis_b = s_tdata[31:16];
    assign geom_in.center_x    = s_tdata[63:48];
    assign geom_in.center_y    = s_tdata[79:64];

    always_ff @(posedge aclk) begin
        if (en) begin
            geom_reg[0] <= geom_in;
            for (int i = 1; i < DL; i++) begin
                geom_reg[i] <= geom_reg[i-1];
            end
        end
    end

    recc_sincos u_sincos (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .angle    (s_tdata[47:32]),
        .out_valid(sc_valid),
        .sin_q14  (sin_q14),
        .cos_q14  (cos_q14)
    );

    recc_coef u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sc_valid),
        .geom      (geom_reg[DL-1]),
        .sin_q14   (sin_q14),
        .cos_q14   (cos_q14),
        .out_valid (m_tvalid),
        .coef_xx   (coef_xx),
        .coef_yy   (coef_yy),
        .coef_xy   (coef_xy),
        .coef_x    (coef_x),
        .coef_y    (coef_y),
        .coef_const(coef_const)
    );

    assign m_tdata = {coef_const, coef_y, coef_x, coef_xy, coef_yy, coef_xx};

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while the output is stalled");

    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sc_valid |-> (sin_q14 <= 16'sd16384 && sin_q14 >= -16'sd16384 &&
                      cos_q14 <= 16'sd16384 && cos_q14 >= -16'sd16384))
        else $error("sine or cosine out of range");

    a_square_terms_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!coef_xx[63] && !coef_yy[63]))
        else $error("negative squared-term coefficient");

endmodule

// File: verif/rotated_ellipse_conic_coeffs_unit_tb.sv
// Testbench for the rotated ellipse to general conic coefficient unit.
`timescale 1ns / 100ps

module rotated_ellipse_conic_coeffs_unit_tb;

    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [383:0] m_tdata;

    logic [383:0] coeffs_pending[$];
    int           error_count;
    bit           sender_idle_en;
    bit           receiver_idle_en;
    bit           hold_req;
    bit           hold_done;

    rotated_ellipse_conic_coeffs_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic longint unsigned floor_one_minus(longint unsigned v);
        return (v >= ONE_Q30) ? 64'd0 : ONE_Q30 - v;
    endfunction

    function automatic void sine_cosine(input logic [15:0] angle,
                                        output longint sn, output longint cs);
        longint unsigned x, x2, ts, tc;
        longint s, c;
        ts = ONE_Q30;
        tc = ONE_Q30;
        x  = ((64'(angle[13:0]) * 64'(recc_pkg::PI_Q48)) + (64'd1 << 32)) >> 33;
        x2 = (x * x) >> 30;
        for (int k = 7; k >= 1; k--) begin
            ts = floor_one_minus(((x2 * ts) >> 30) / 64'((2 * k) * (2 * k + 1)));
        end
        for (int k = 8; k >= 1; k--) begin
            tc = floor_one_minus(((x2 * tc) >> 30) / 64'((2 * k - 1) * (2 * k)));
        end
        s = longint'((((x * ts) >> 30) + (64'd1 << 15)) >> 16);
        c = longint'((tc + (64'd1 << 15)) >> 16);
        case (angle[15:14])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    function automatic logic [383:0] conic_coeffs(logic [79:0] d);
        logic signed [127:0] a, b, cx, cy, s, c, a2, b2, t1, t2, t3, acc;
        longint sn, cs;
        logic [383:0] r;
        sine_cosine(d[47:32], sn, cs);
        a  = {112'd0, d[15:0]};
        b  = {112'd0, d[31:16]};
        cx = $signed(d[63:48]);
        cy = $signed(d[79:64]);
        s  = sn;
        c  = cs;
        a2 = a * a;
        b2 = b * b;
        t1 = a2 * s * s + b2 * c * c;
        t3 = b2 * s * s + a2 * c * c;
        t2 = 2 * (b2 - a2) * s * c;
        r[63:0]    = 64'(t1 >>> 28);
        r[127:64]  = 64'(t3 >>> 28);
        r[191:128] = 64'(t2 >>> 28);
        acc = t1 * (-2 * cx) + t2 * (-cy);
        r[255:192] = 64'(acc >>> 36);
        acc = t3 * (-2 * cy) + t2 * (-cx);
        r[319:256] = 64'(acc >>> 36);
        acc = t1 * cx * cx + t2 * cx * cy + t3 * cy * cy - ((a2 * b2) <<< 28);
        r[383:320] = 64'(acc >>> 44);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        logic [383:0] want;
        string names[6];
        names = '{"coef_xx", "coef_yy", "coef_xy", "coef_x", "coef_y", "coef_const"};
        if (aresetn) begin
            if (s_tvalid && s_tready)
                coeffs_pending.insert(coeffs_pending.size(), conic_coeffs(s_tdata));
            if (m_tvalid && m_tready) begin
                if (coeffs_pending.size() == 0) begin
                    report_mismatch("result with no item outstanding", m_tdata[63:0], 64'd0);
                end else begin
                    want = coeffs_pending.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        if (m_tdata[64*i +: 64] !== want[64*i +: 64])
                            report_mismatch(names[i], m_tdata[64*i +: 64], want[64*i +: 64]);
                    end
                end
            end
        end
    end

    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                for (n = 0; n < 300; n++) @(negedge aclk);
                hold_req  = 1'b0;
                hold_done = 1'b1;
                m_tready  = 1'b1;
            end else if (receiver_idle_en && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_item(logic [79:0] d);
        if (sender_idle_en && $urandom_range(0, 7) == 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic release_input;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained;
        while (coeffs_pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_field();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [79:0] random_ellipse();
        return {pick_field(), pick_field(), pick_field(), pick_field(), pick_field()};
    endfunction

    task automatic test_directed;
        logic [15:0] angles[8];
        angles = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF,
                   16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
        foreach (angles[i]) send_item({16'h0100, 16'hFF00, angles[i], 16'h0280, 16'h0100});
        send_item({16'h0000, 16'h0000, 16'h1234, 16'h0000, 16'h0000});
        send_item({16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF});
        send_item({16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000});
        send_item({16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000});
        send_item({16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF});
        send_item({16'h7FFF, 16'h8000, 16'h2000, 16'h0000, 16'h0001});
        send_item({16'hFFFF, 16'hFFFF, 16'hE000, 16'h0000, 16'h0000});
        send_item({16'h8000, 16'h7FFF, 16'h6000, 16'hFFFF, 16'hFFFF});
        release_input();
    endtask

    task automatic test_output_hold_off;
        hold_done = 1'b0;
        hold_req  = 1'b1;
        for (int i = 0; i < 80; i++) send_item(random_ellipse());
        release_input();
        wait (hold_done);
    endtask

    task automatic test_drain_pause;
        for (int i = 0; i < 40; i++) send_item(random_ellipse());
        release_input();
        wait_drained();
        for (int i = 0; i < 20; i++) send_item(random_ellipse());
        release_input();
    endtask

    task automatic test_random_stream(int count);
        for (int i = 0; i < count; i++) send_item(random_ellipse());
        release_input();
    endtask

    initial begin
        error_count      = 0;
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        hold_req         = 1'b0;
        hold_done        = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        aresetn          = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
        test_output_hold_off();
        test_drain_pause();
        test_random_stream(1150);
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        test_random_stream(140);
        wait_drained();
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/recc_pkg.sv
hw/rtl/recc_step.sv
hw/rtl/recc_sincos.sv
hw/rtl/recc_coef.sv
hw/rtl/rotated_ellipse_conic_coeffs_unit.sv
verif/rotated_ellipse_conic_coeffs_unit_tb.sv
